### hdl/osv_pkg.sv
// Package for the odd-only sieve prime generator: constants, control types and sequencer states.
`default_nettype none
package osv_pkg;

	// Default largest limit that the candidate map can hold.
	localparam int unsigned LIMIT_MAX_DEF = 65535;

	// Field widths of the register and of the result word.
	localparam int LIMIT_W = 16;
	localparam int PRIME_W = 16;

	// Value of the limit register after reset.
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

	// The only even prime and the first odd candidate.
	localparam int unsigned FIRST_PRIME = 2;
	localparam int unsigned FIRST_ODD   = 3;

	// Control of the candidate map ports.
	typedef struct packed {
		logic wr_en;
		logic wr_bit;
		logic rd_en;
	} map_ctl_t;

	// Sequencer states, one-hot.
	typedef enum logic [8:0] {
		ST_FILL     = 9'b000000001,
		ST_IDLE     = 9'b000000010,
		ST_SERVE    = 9'b000000100,
		ST_SCAN_RD  = 9'b000001000,
		ST_SCAN_CHK = 9'b000010000,
		ST_SQ       = 9'b000100000,
		ST_SQ_CMP   = 9'b001000000,
		ST_MARK     = 9'b010000000,
		ST_RESULT   = 9'b100000000
	} state_t;

endpackage
`default_nettype wire

### hdl/osv_map.sv
// Candidate map memory: one bit for each odd value, one write and one registered read port.
`default_nettype none
module osv_map #(
	parameter int DEPTH = 32768,
	parameter int AW    = 15
) (
	input  wire                  clk,
	input  wire osv_pkg::map_ctl_t ctl,
	input  wire  [AW-1:0]        waddr,
	input  wire  [AW-1:0]        raddr,
	output logic                 rdata
);
	import osv_pkg::*;

	logic mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= ctl.wr_bit;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### hdl/osv_core.sv
// Sieve sequencer: fills the map, scans odd candidates and clears multiples with one shared adder.
`default_nettype none
module osv_core #(
	parameter int DEPTH = 32768,
	parameter int AW    = 15,
	parameter int VW    = 17
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  wire                        restart,
	input  wire  [VW-1:0]              lim,
	output logic                       ready,
	output logic                       res_valid,
	input  wire                        res_take,
	output logic [osv_pkg::PRIME_W-1:0] res_prime,
	output logic                       res_done,
	output osv_pkg::map_ctl_t          map_ctl,
	output logic [AW-1:0]              map_waddr,
	output logic [AW-1:0]              map_raddr,
	input  wire                        map_rdata
);
	import osv_pkg::*;

	localparam int MW = VW + 1;
	localparam int PW = 2 * VW;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	state_t              state_q;
	logic                serve_q;
	logic [AW-1:0]       fill_q;
	logic [VW-1:0]       cursor_q;
	logic [VW-1:0]       cand_q;
	logic [PW-1:0]       sq_q;
	logic [MW-1:0]       mult_q;
	logic [PRIME_W-1:0]  prime_q;
	logic                done_q;

	logic [MW-1:0]       lim_m;
	logic [PW-1:0]       lim_p;
	logic [MW-1:0]       step;
	logic [MW-1:0]       add_a;
	logic [MW-1:0]       add_b;
	logic [MW-1:0]       add_sum;

	assign lim_m = MW'(lim);
	assign lim_p = PW'(lim);
	assign step  = {cand_q, 1'b0};

	// Shared adder: next odd candidate while scanning, next multiple while marking.
	always_comb begin
		add_a = MW'(cand_q);
		add_b = MW'(FIRST_PRIME);
		if (state_q == ST_MARK) begin
			add_a = mult_q;
			add_b = step;
		end
	end
	assign add_sum = add_a + add_b;

	// Map port control.
	always_comb begin
		map_ctl.wr_en  = 1'b0;
		map_ctl.wr_bit = 1'b0;
		map_ctl.rd_en  = 1'b0;
		map_waddr      = fill_q;
		map_raddr      = cand_q[AW:1];
		case (state_q)
			ST_FILL: begin
				map_ctl.wr_en  = 1'b1;
				map_ctl.wr_bit = 1'b1;
			end
			ST_SCAN_RD: begin
				map_ctl.rd_en = (cand_q <= lim);
			end
			ST_MARK: begin
				map_ctl.wr_en = (mult_q <= lim_m);
				map_waddr     = mult_q[AW:1];
			end
			default: begin
			end
		endcase
	end

	assign ready     = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_RESULT);
	assign res_prime = prime_q;
	assign res_done  = done_q;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_FILL;
			serve_q  <= 1'b0;
			fill_q   <= '0;
			cursor_q <= VW'(FIRST_PRIME);
		end else begin
			case (state_q)
				ST_FILL: begin
					fill_q <= fill_q + AW'(1);
					if (fill_q == LAST_ADDR) begin
						fill_q  <= '0;
						state_q <= serve_q ? ST_SERVE : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						if (restart) begin
							serve_q  <= 1'b1;
							cursor_q <= VW'(FIRST_PRIME);
							state_q  <= ST_FILL;
						end else begin
							state_q <= ST_SERVE;
						end
					end
				end
				ST_SERVE: begin
					serve_q <= 1'b0;
					if (cursor_q == VW'(FIRST_PRIME)) begin
						state_q <= ST_RESULT;
						if (lim >= VW'(FIRST_PRIME)) begin
							cursor_q <= VW'(FIRST_ODD);
						end
					end else begin
						state_q <= ST_SCAN_RD;
					end
				end
				ST_SCAN_RD: begin
					if (cand_q > lim) begin
						cursor_q <= cand_q;
						state_q  <= ST_RESULT;
					end else begin
						state_q <= ST_SCAN_CHK;
					end
				end
				ST_SCAN_CHK: begin
					state_q <= map_rdata ? ST_SQ : ST_SCAN_RD;
				end
				ST_SQ: begin
					state_q <= ST_SQ_CMP;
				end
				ST_SQ_CMP: begin
					if (sq_q <= lim_p) begin
						state_q <= ST_MARK;
					end else begin
						cursor_q <= add_sum[VW-1:0];
						state_q  <= ST_RESULT;
					end
				end
				ST_MARK: begin
					if (mult_q > lim_m) begin
						cursor_q <= cand_q + VW'(FIRST_PRIME);
						state_q  <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: candidate, square, multiple and the result word.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_SERVE: begin
				cand_q <= cursor_q | VW'(1);
				if (cursor_q == VW'(FIRST_PRIME)) begin
					if (lim >= VW'(FIRST_PRIME)) begin
						prime_q <= PRIME_W'(FIRST_PRIME);
						done_q  <= 1'b0;
					end else begin
						prime_q <= '0;
						done_q  <= 1'b1;
					end
				end
			end
			ST_SCAN_RD: begin
				if (cand_q > lim) begin
					prime_q <= '0;
					done_q  <= 1'b1;
				end
			end
			ST_SCAN_CHK: begin
				if (!map_rdata) begin
					cand_q <= add_sum[VW-1:0];
				end
			end
			ST_SQ: begin
				sq_q <= PW'(cand_q) * PW'(cand_q);
			end
			ST_SQ_CMP: begin
				mult_q  <= sq_q[MW-1:0];
				prime_q <= PRIME_W'(cand_q);
				done_q  <= 1'b0;
			end
			ST_MARK: begin
				mult_q <= add_sum;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

### hdl/odd_eratosthenes_sieve_unit.sv
// Top level of the odd-only sieve prime generator: limit register, output register and hookup.
//
//  channel  | direction | handshake             | word
//  request  | in        | in_valid / in_stall   | restart
//  result   | out       | out_valid / out_stall | prime, done_res
//  config   | in        | cfg_we                | cfg_wdata (limit)
//
// A request returns the prime 2 first; after that it scans odd candidates through the map and,
// when the prime's square is within the limit, clears each multiple up to the limit before the
// result; an exhausted request returns done. The map has a single write port, and scanning and
// clearing share one adder.
// After reset, and for a request with restart set, every entry of the map is set before going on.
// The output register holds one word; a finished result waits in the sequencer while it is full and stalled.
// in_stall is high whenever the sequencer is not idle.
`default_nettype none
module odd_eratosthenes_sieve_unit #(
	parameter int unsigned LIMIT_MAX = osv_pkg::LIMIT_MAX_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire                         restart,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic [osv_pkg::PRIME_W-1:0] prime,
	output logic                        done_res,
	input  wire                         cfg_we,
	input  wire  [osv_pkg::LIMIT_W-1:0] cfg_wdata
);
	import osv_pkg::*;

	localparam int DEPTH = LIMIT_MAX / 2 + 1;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int VW    = $clog2(LIMIT_MAX + 1) + 1;
	localparam int CMPW  = (VW > LIMIT_W) ? VW : LIMIT_W;

	logic [LIMIT_W-1:0] limit_q;
	logic [CMPW-1:0]    lim_ext;
	logic [CMPW-1:0]    lim_sat;
	logic [VW-1:0]      lim;

	logic               accept;
	logic               ready;
	logic               res_valid;
	logic               res_take;
	logic [PRIME_W-1:0] res_prime;
	logic               res_done;

	map_ctl_t           map_ctl;
	logic [AW-1:0]      map_waddr;
	logic [AW-1:0]      map_raddr;
	logic               map_rdata;

	logic               out_valid_q;
	logic [PRIME_W-1:0] prime_q;
	logic               done_q;

	// Limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// The effective limit saturates at the map size.
	assign lim_ext = CMPW'(limit_q);
	assign lim_sat = (lim_ext > CMPW'(LIMIT_MAX)) ? CMPW'(LIMIT_MAX) : lim_ext;
	assign lim     = lim_sat[VW-1:0];

	assign in_stall = !ready;
	assign accept   = in_valid && ready;

	osv_core #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.VW    (VW)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.restart   (restart),
		.lim       (lim),
		.ready     (ready),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res_prime (res_prime),
		.res_done  (res_done),
		.map_ctl   (map_ctl),
		.map_waddr (map_waddr),
		.map_raddr (map_raddr),
		.map_rdata (map_rdata)
	);

	osv_map #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_map (
		.clk   (clk),
		.ctl   (map_ctl),
		.waddr (map_waddr),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	// Output register: loads a finished word when empty or being taken.
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			prime_q <= res_prime;
			done_q  <= res_done;
		end
	end

	assign out_valid = out_valid_q;
	assign prime     = prime_q;
	assign done_res  = done_q;

endmodule
`default_nettype wire
